// ----- hdl/bta_pkg.sv -----
// Shared types and constants for the balanced-ternary word ALU.
// Used by bta_div_step and balanced_ternary_word_alu; no dependencies.
package bta_pkg;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_NEG  = 4'd2;
  localparam logic [3:0] ACT_MUL  = 4'd3;
  localparam logic [3:0] ACT_DIV  = 4'd4;
  localparam logic [3:0] ACT_MOD  = 4'd5;
  localparam logic [3:0] ACT_CMP  = 4'd6;
  localparam logic [3:0] ACT_FROM = 4'd7;
  localparam logic [3:0] ACT_TO   = 4'd8;

  localparam int GROUP_BIAS  = 121;
  localparam int GROUP_RADIX = 243;
  localparam int WORD_LIMIT  = 29524;
  localparam int GROUP_MAX   = 242;
  // floor(2^24 / 243); quotient is low by at most one, fixed by one compare
  localparam int RECIP       = 69042;
  localparam int RECIP_SHIFT = 24;

  localparam int NUM_W      = 20;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;

  typedef struct packed {
    logic [3:0]          act;
    logic                err;
    logic signed [15:0]  a;
    logic signed [15:0]  b;
    logic signed [31:0]  val;
    logic signed [1:0]   cmp;
    logic signed [15:0]  bin;
    logic [NUM_W-1:0]    num;
    logic [15:0]         den;
    logic [16:0]         rem;
    logic                neg_q;
    logic [15:0]         t;
    logic [7:0]          q0;
  } pl_t;

  // value of a packed word, no validity check
  function automatic logic signed [15:0] word_value(input logic [15:0] w);
    logic signed [16:0] lo_s;
    logic signed [16:0] hi_s;
    logic signed [16:0] sum;
    lo_s = $signed({9'b0, w[7:0]}) - 17'sd121;
    hi_s = $signed({9'b0, w[15:8]}) - 17'sd121;
    sum  = lo_s + hi_s * 17'sd243;
    return sum[15:0];
  endfunction

endpackage

// ----- hdl/bta_div_step.sv -----
// One registered stage of the restoring divider: DIV_STEPS quotient bits.
// Depends on bta_pkg.
module bta_div_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_in,
  input  bta_pkg::pl_t d_in,
  output logic         vld_out,
  output bta_pkg::pl_t d_out
);

  bta_pkg::pl_t work;
  logic         vld_r;
  bta_pkg::pl_t d_r;

  // quotient bits shift into num from the bottom as the dividend leaves the top
  always_comb begin
    work = d_in;
    for (int i = 0; i < bta_pkg::DIV_STEPS; i++) begin
      work.rem = {work.rem[15:0], work.num[bta_pkg::NUM_W-1]};
      work.num = {work.num[bta_pkg::NUM_W-2:0], 1'b0};
      if (work.rem >= {1'b0, work.den}) begin
        work.rem    = work.rem - {1'b0, work.den};
        work.num[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    d_r <= work;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// ----- hdl/balanced_ternary_word_alu.sv -----
// Top level of the balanced-ternary word ALU pipeline.
// Depends on bta_pkg and bta_div_step.
//
// Takes one request per cycle (busy is always low) and returns exactly one
// result per request, in request order; the result is shown for one cycle
// with out_valid and cannot be stalled. The pipeline is the 20-bit restoring
// divider (five stages of four bits) plus the decode, operate, sign, range
// and constant-divide-by-243 stages.
module balanced_ternary_word_alu #(
  parameter logic [15:0] ERROR_WORD = 16'hFFFF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_action,
  input  logic [15:0]        in_operand_a,
  input  logic [15:0]        in_operand_b,
  input  logic signed [31:0] in_binary_value,
  output logic               out_valid,
  output logic [15:0]        out_packed_result,
  output logic signed [15:0] out_binary_result,
  output logic signed [1:0]  out_compare_result,
  output logic               out_error_flag
);

  localparam int NS = bta_pkg::DIV_STAGES;

  function automatic logic bad_word(input logic [15:0] w);
    return (w == ERROR_WORD) || (w[7:0] > 8'(bta_pkg::GROUP_MAX))
        || (w[15:8] > 8'(bta_pkg::GROUP_MAX));
  endfunction

  function automatic logic has_word(input logic [3:0] act);
    return act <= bta_pkg::ACT_MOD || act == bta_pkg::ACT_FROM;
  endfunction

  assign busy = 1'b0;

  // stage 1: decode
  logic         v1_r;
  bta_pkg::pl_t s1_r, s1_nxt;
  logic         need_a, need_b;

  always_comb begin
    need_a = in_action <= bta_pkg::ACT_CMP || in_action == bta_pkg::ACT_TO;
    need_b = in_action <= bta_pkg::ACT_CMP && in_action != bta_pkg::ACT_NEG;
    s1_nxt     = '0;
    s1_nxt.act = in_action;
    s1_nxt.a   = bta_pkg::word_value(in_operand_a);
    s1_nxt.b   = bta_pkg::word_value(in_operand_b);
    s1_nxt.val = in_binary_value;
    s1_nxt.err = (in_action > bta_pkg::ACT_TO) || (need_a && bad_word(in_operand_a))
               || (need_b && bad_word(in_operand_b));
  end

  // stage 2: operate
  logic         v2_r;
  bta_pkg::pl_t s2_r, s2_nxt;
  logic signed [31:0] a32, b32;
  logic [14:0]  ma, mb;

  always_comb begin
    s2_nxt = s1_r;
    a32 = {{16{s1_r.a[15]}}, s1_r.a};
    b32 = {{16{s1_r.b[15]}}, s1_r.b};
    ma  = s1_r.a[15] ? 15'(-s1_r.a) : s1_r.a[14:0];
    mb  = s1_r.b[15] ? 15'(-s1_r.b) : s1_r.b[14:0];
    s2_nxt.neg_q = s1_r.a[15] ^ s1_r.b[15];
    s2_nxt.rem   = '0;
    s2_nxt.num   = {5'b0, ma};
    s2_nxt.den   = {1'b0, mb};
    unique case (s1_r.act)
      bta_pkg::ACT_ADD: s2_nxt.val = a32 + b32;
      bta_pkg::ACT_SUB: s2_nxt.val = a32 - b32;
      bta_pkg::ACT_NEG: s2_nxt.val = -a32;
      bta_pkg::ACT_MUL: s2_nxt.val = s1_r.a * s1_r.b;
      bta_pkg::ACT_DIV: begin
        if (s1_r.b == 16'sd0) s2_nxt.err = 1'b1;
      end
      bta_pkg::ACT_MOD: begin
        if (s1_r.b == 16'sd0) s2_nxt.err = 1'b1;
        // (2|a| + |b|) / (2|b|) rounds half away from zero
        s2_nxt.num = {4'b0, ma, 1'b0} + {5'b0, mb};
        s2_nxt.den = {mb, 1'b0};
      end
      bta_pkg::ACT_CMP:
        s2_nxt.cmp = (s1_r.a < s1_r.b) ? -2'sd1 : (s1_r.a > s1_r.b) ? 2'sd1 : 2'sd0;
      bta_pkg::ACT_TO:   s2_nxt.bin = s1_r.a;
      default: ;
    endcase
  end

  // divider stages
  logic         dv_v [0:NS];
  bta_pkg::pl_t dv_d [0:NS];

  assign dv_v[0] = v2_r;
  assign dv_d[0] = s2_r;

  for (genvar g = 0; g < NS; g++) begin : g_div
    bta_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (dv_v[g]),
      .d_in   (dv_d[g]),
      .vld_out(dv_v[g+1]),
      .d_out  (dv_d[g+1])
    );
  end

  // stage 8: signed quotient, remainder product
  logic         v8_r;
  bta_pkg::pl_t s8_r, s8_nxt;
  logic signed [16:0] qs;

  always_comb begin
    s8_nxt = dv_d[NS];
    qs = dv_d[NS].neg_q ? -$signed({1'b0, dv_d[NS].num[15:0]})
                        : $signed({1'b0, dv_d[NS].num[15:0]});
    if (dv_d[NS].act == bta_pkg::ACT_DIV) begin
      s8_nxt.val = {{15{qs[16]}}, qs};
    end else if (dv_d[NS].act == bta_pkg::ACT_MOD) begin
      s8_nxt.val = dv_d[NS].b * qs;
    end
  end

  // stage 9: final value, range check, offset
  logic         v9_r;
  bta_pkg::pl_t s9_r, s9_nxt;
  logic signed [31:0] fv;

  always_comb begin
    s9_nxt = s8_r;
    fv = (s8_r.act == bta_pkg::ACT_MOD) ? {{16{s8_r.a[15]}}, s8_r.a} - s8_r.val
                                        : s8_r.val;
    if (has_word(s8_r.act)
        && (fv < -32'sd29524 || fv > 32'(bta_pkg::WORD_LIMIT))) begin
      s9_nxt.err = 1'b1;
    end
    s9_nxt.t = 16'(fv + 32'(bta_pkg::WORD_LIMIT));
  end

  // stage 10: estimate of t / 243
  logic         v10_r;
  bta_pkg::pl_t s10_r, s10_nxt;
  logic [33:0]  rprod;

  always_comb begin
    s10_nxt = s9_r;
    rprod   = 34'(s9_r.t) * 34'(bta_pkg::RECIP);
    s10_nxt.q0 = rprod[bta_pkg::RECIP_SHIFT +: 8];
  end

  // stage 11: correct quotient, pack, output
  logic [15:0] rr;
  logic [7:0]  hi_g, lo_g;
  logic [15:0] packed_nxt;

  always_comb begin
    rr   = s10_r.t - 16'(s10_r.q0) * 16'(bta_pkg::GROUP_RADIX);
    hi_g = s10_r.q0;
    if (rr >= 16'(bta_pkg::GROUP_RADIX)) begin
      rr   = rr - 16'(bta_pkg::GROUP_RADIX);
      hi_g = hi_g + 8'd1;
    end
    lo_g = rr[7:0];
    packed_nxt = has_word(s10_r.act) ? {hi_g, lo_g} : 16'd0;
  end

  logic               out_valid_r;
  logic [15:0]        out_packed_r;
  logic signed [15:0] out_bin_r;
  logic signed [1:0]  out_cmp_r;
  logic               out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start;
      v2_r        <= v1_r;
      v8_r        <= dv_v[NS];
      v9_r        <= v8_r;
      v10_r       <= v9_r;
      out_valid_r <= v10_r;
    end
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s8_r  <= s8_nxt;
    s9_r  <= s9_nxt;
    s10_r <= s10_nxt;
    out_err_r    <= s10_r.err;
    out_packed_r <= s10_r.err ? ERROR_WORD : packed_nxt;
    out_bin_r    <= s10_r.err ? 16'sd0 : s10_r.bin;
    out_cmp_r    <= s10_r.err ? 2'sd0 : s10_r.cmp;
  end

  assign out_valid          = out_valid_r;
  assign out_packed_result  = out_packed_r;
  assign out_binary_result  = out_bin_r;
  assign out_compare_result = out_cmp_r;
  assign out_error_flag     = out_err_r;

endmodule

// ----- hdl/bta_checker.sv -----
// Port-level checks for balanced_ternary_word_alu, bound to the top level.
// Depends on balanced_ternary_word_alu ports only.
module bta_checker #(
  parameter logic [15:0] ERROR_WORD = 16'hFFFF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [15:0]        out_packed_result,
  input logic signed [15:0] out_binary_result,
  input logic signed [1:0]  out_compare_result,
  input logic               out_error_flag
);

  // every request comes out after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##11 out_valid) else $error("result missing");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy asserted");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_packed_result == ERROR_WORD
      && out_binary_result == 16'sd0 && out_compare_result == 2'sd0)
    else $error("error result fields wrong");

  a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_compare_result != -2'sd2) else $error("bad compare code");

endmodule

bind balanced_ternary_word_alu bta_checker #(.ERROR_WORD(ERROR_WORD)) u_bta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_packed_result (out_packed_result),
  .out_binary_result (out_binary_result),
  .out_compare_result(out_compare_result),
  .out_error_flag    (out_error_flag)
);
